// File: rtl/core/izs_pkg.sv
// ----------------------------------------------------------------------------
// izs_pkg
// Shared types and constants of the irrigation zone scheduler.
// ----------------------------------------------------------------------------
package izs_pkg;

  // Default number of zones
  localparam int NumZonesDef = 8;

  // Widths fixed by the item fields
  localparam int ZoneIdxW = 3;
  localparam int HumW     = 10;
  localparam int TimeW    = 32;
  localparam int MinuteW  = 11;
  localparam int SecW     = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [TimeW-1:0] MsPerSec = 32'd1000;

  // Register reset values
  localparam logic               RstStartMode = 1'b0;
  localparam logic [MinuteW-1:0] RstWinStart  = 11'd360;
  localparam logic [MinuteW-1:0] RstWinEnd    = 11'd480;
  localparam logic [SecW-1:0]    RstRunLimit  = 16'd600;
  localparam logic [SecW-1:0]    RstRetry     = 16'd3600;
  localparam logic [HumW-1:0]    RstStartBel  = 10'd300;
  localparam logic [HumW-1:0]    RstStopAbv   = 10'd600;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MODE  = 3'd0,
    CFG_WIN_START   = 3'd1,
    CFG_WIN_END     = 3'd2,
    CFG_RUN_LIMIT   = 3'd3,
    CFG_RETRY_DELAY = 3'd4,
    CFG_START_BELOW = 3'd5,
    CFG_STOP_ABOVE  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    OP_SENSOR = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    RSN_HUMIDITY = 2'd0,
    RSN_WINDOW   = 2'd1,
    RSN_RUNTIME  = 2'd2
  } reason_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FIN
  } state_e;

  // Configuration seen by the scheduler; limits already scaled to ms
  typedef struct packed {
    logic               start_mode;
    logic [MinuteW-1:0] win_start;
    logic [MinuteW-1:0] win_end;
    logic [TimeW-1:0]   run_ms;
    logic [TimeW-1:0]   retry_ms;
    logic [HumW-1:0]    start_below;
    logic [HumW-1:0]    stop_above;
  } cfg_t;

endpackage

// File: rtl/core/izs_cfg_regs.sv
// ----------------------------------------------------------------------------
// izs_cfg_regs
// Configuration register file; time limits are stored as milliseconds.
// ----------------------------------------------------------------------------
module izs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [izs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [izs_pkg::CfgDataW-1:0]  cfg_data_i,
  output izs_pkg::cfg_t                 cfg_o
);

  izs_pkg::cfg_t cfg_q, cfg_d;
  logic [izs_pkg::TimeW-1:0] data_ms;
  logic                      wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i && cfg_ready_o;

  // seconds to milliseconds, one constant multiply per write
  assign data_ms = izs_pkg::TimeW'(cfg_data_i) * izs_pkg::MsPerSec;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_index_i)
        izs_pkg::CFG_START_MODE:  cfg_d.start_mode  = cfg_data_i[0];
        izs_pkg::CFG_WIN_START:   cfg_d.win_start   = cfg_data_i[izs_pkg::MinuteW-1:0];
        izs_pkg::CFG_WIN_END:     cfg_d.win_end     = cfg_data_i[izs_pkg::MinuteW-1:0];
        izs_pkg::CFG_RUN_LIMIT:   cfg_d.run_ms      = data_ms;
        izs_pkg::CFG_RETRY_DELAY: cfg_d.retry_ms    = data_ms;
        izs_pkg::CFG_START_BELOW: cfg_d.start_below = cfg_data_i[izs_pkg::HumW-1:0];
        izs_pkg::CFG_STOP_ABOVE:  cfg_d.stop_above  = cfg_data_i[izs_pkg::HumW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_mode  <= izs_pkg::RstStartMode;
      cfg_q.win_start   <= izs_pkg::RstWinStart;
      cfg_q.win_end     <= izs_pkg::RstWinEnd;
      cfg_q.run_ms      <= izs_pkg::TimeW'(izs_pkg::RstRunLimit) * izs_pkg::MsPerSec;
      cfg_q.retry_ms    <= izs_pkg::TimeW'(izs_pkg::RstRetry) * izs_pkg::MsPerSec;
      cfg_q.start_below <= izs_pkg::RstStartBel;
      cfg_q.stop_above  <= izs_pkg::RstStopAbv;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/izs_zone_mem.sv
// ----------------------------------------------------------------------------
// izs_zone_mem
// Per-zone humidity and last-close time, one shared registered read port.
// ----------------------------------------------------------------------------
module izs_zone_mem #(
  parameter int NUM_ZONES = izs_pkg::NumZonesDef
) (
  input  logic                                               clk_i,
  input  logic                                               hum_we_i,
  input  logic [((NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1)-1:0] hum_waddr_i,
  input  logic [izs_pkg::HumW-1:0]                           hum_wdata_i,
  input  logic                                               lc_we_i,
  input  logic [((NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1)-1:0] lc_waddr_i,
  input  logic [izs_pkg::TimeW-1:0]                          lc_wdata_i,
  input  logic [((NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1)-1:0] raddr_i,
  output logic [izs_pkg::HumW-1:0]                           hum_rdata_o,
  output logic [izs_pkg::TimeW-1:0]                          lc_rdata_o
);

  logic [izs_pkg::HumW-1:0]  hum_mem [NUM_ZONES];
  logic [izs_pkg::TimeW-1:0] lc_mem  [NUM_ZONES];

  // humidity store
  always_ff @(posedge clk_i) begin
    if (hum_we_i) begin
      hum_mem[hum_waddr_i] <= hum_wdata_i;
    end
    hum_rdata_o <= hum_mem[raddr_i];
  end

  // last close time store
  always_ff @(posedge clk_i) begin
    if (lc_we_i) begin
      lc_mem[lc_waddr_i] <= lc_wdata_i;
    end
    lc_rdata_o <= lc_mem[raddr_i];
  end

endmodule

// File: rtl/core/izs_elapsed_cmp.sv
// ----------------------------------------------------------------------------
// izs_elapsed_cmp
// Shared elapsed-time unit: (now - then) mod 2^32 >= limit in ms.
// ----------------------------------------------------------------------------
module izs_elapsed_cmp (
  input  logic [izs_pkg::TimeW-1:0] now_i,
  input  logic [izs_pkg::TimeW-1:0] then_i,
  input  logic [izs_pkg::TimeW-1:0] limit_ms_i,
  output logic                      ge_o
);

  logic [izs_pkg::TimeW-1:0] diff;

  // floor(diff/1000) >= L holds exactly when diff >= 1000*L
  assign diff = now_i - then_i;
  assign ge_o = (diff >= limit_ms_i);

endmodule

// File: rtl/core/irrigation_zone_scheduler_unit.sv
// ----------------------------------------------------------------------------
// irrigation_zone_scheduler_unit
// Keeps at most one valve open; closes on wet, window end or run limit and
// opens the next dry, rested zone round-robin.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------
//   in      | in  | in_valid_i/in_ready_o  | opcode .. clock_valid
//   out     | out | out_valid_o/out_ready_i| valve_closed .. valve_active
//   cfg     | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A sensor request is answered in the next cycle. A tick goes S_CLOSE, then
// S_SCAN_RD and S_SCAN_EV if it searches, then S_FIN; the search visits one
// zone per cycle through the registered zone memory read and the shared
// elapsed-time comparator. in_ready_o is low while a tick is in progress and
// while an unaccepted result would be overwritten. Reset clears the valve
// state, pointer, usable and closed flags; the zone memories need no clear.
// ----------------------------------------------------------------------------
module irrigation_zone_scheduler_unit #(
  parameter int NUM_ZONES = izs_pkg::NumZonesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [izs_pkg::ZoneIdxW-1:0]  zone_index_i,
  input  logic [izs_pkg::HumW-1:0]      humidity_tenths_i,
  input  logic                          reading_usable_i,
  input  logic [izs_pkg::TimeW-1:0]     now_ms_i,
  input  logic [izs_pkg::MinuteW-1:0]   minute_of_day_i,
  input  logic                          clock_valid_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          valve_closed_o,
  output logic [izs_pkg::ZoneIdxW-1:0]  closed_zone_o,
  output logic [1:0]                    close_reason_o,
  output logic                          valve_opened_o,
  output logic [izs_pkg::ZoneIdxW-1:0]  opened_zone_o,
  output logic                          valve_active_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [izs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [izs_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam logic [ZW-1:0] LastZone = ZW'(NUM_ZONES - 1);

  izs_pkg::cfg_t   cfg;
  izs_pkg::state_e state_q, state_d;

  logic                        valve_on_q, valve_on_d;
  logic [ZW-1:0]               active_zone_q, active_zone_d;
  logic [izs_pkg::TimeW-1:0]   opened_at_q, opened_at_d;
  logic [ZW-1:0]               next_zone_q, next_zone_d;
  logic [NUM_ZONES-1:0]        has_closed_q, has_closed_d;
  logic [NUM_ZONES-1:0]        usable_q, usable_d;
  logic [izs_pkg::TimeW-1:0]   now_q, now_d;
  logic                        allowed_q, allowed_d;
  logic [ZW-1:0]               scan_z_q, scan_z_d;
  logic [ZW-1:0]               scan_cnt_q, scan_cnt_d;
  logic                        res_closed_q, res_closed_d;
  logic [ZW-1:0]               res_czone_q, res_czone_d;
  izs_pkg::reason_e            res_reason_q, res_reason_d;
  logic                        res_opened_q, res_opened_d;
  logic [ZW-1:0]               res_ozone_q, res_ozone_d;

  logic                        out_valid_q, out_valid_d;
  logic                        out_closed_q, out_closed_d;
  logic [izs_pkg::ZoneIdxW-1:0] out_czone_q, out_czone_d;
  logic [1:0]                  out_reason_q, out_reason_d;
  logic                        out_opened_q, out_opened_d;
  logic [izs_pkg::ZoneIdxW-1:0] out_ozone_q, out_ozone_d;
  logic                        out_active_q, out_active_d;

  logic                        in_acc;
  logic                        win_allowed;
  logic                        sens_in_range;
  logic [ZW-1:0]               sens_addr;
  logic [ZW-1:0]               mem_raddr;
  logic                        hum_we;
  logic                        lc_we;
  logic [izs_pkg::HumW-1:0]    hum_rdata;
  logic [izs_pkg::TimeW-1:0]   lc_rdata;
  logic [izs_pkg::TimeW-1:0]   cmp_then;
  logic [izs_pkg::TimeW-1:0]   cmp_limit;
  logic                        cmp_ge;
  logic                        hum_stop;
  logic                        do_close;
  izs_pkg::reason_e            close_reason;
  logic                        scan_hit;
  logic [ZW-1:0]               scan_z_inc;
  logic [ZW-1:0]               active_inc;

  // configuration registers
  izs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // zone stores
  izs_zone_mem #(
    .NUM_ZONES (NUM_ZONES)
  ) u_mem (
    .clk_i       (clk_i),
    .hum_we_i    (hum_we),
    .hum_waddr_i (sens_addr),
    .hum_wdata_i (humidity_tenths_i),
    .lc_we_i     (lc_we),
    .lc_waddr_i  (active_zone_q),
    .lc_wdata_i  (now_q),
    .raddr_i     (mem_raddr),
    .hum_rdata_o (hum_rdata),
    .lc_rdata_o  (lc_rdata)
  );

  // shared elapsed-time comparator
  izs_elapsed_cmp u_cmp (
    .now_i      (now_q),
    .then_i     (cmp_then),
    .limit_ms_i (cmp_limit),
    .ge_o       (cmp_ge)
  );

  assign in_ready_o = (state_q == izs_pkg::S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  // sensor write address
  assign sens_in_range = (32'(zone_index_i) < 32'(NUM_ZONES));
  assign sens_addr     = ZW'(zone_index_i);

  // window test on the incoming tick
  always_comb begin
    if (!cfg.start_mode) begin
      win_allowed = 1'b1;
    end else if (!clock_valid_i) begin
      win_allowed = 1'b0;
    end else if (cfg.win_start <= cfg.win_end) begin
      win_allowed = (minute_of_day_i >= cfg.win_start) && (minute_of_day_i <= cfg.win_end);
    end else begin
      win_allowed = (minute_of_day_i >= cfg.win_start) || (minute_of_day_i <= cfg.win_end);
    end
  end

  // round-robin increments
  assign scan_z_inc = (scan_z_q == LastZone) ? '0 : scan_z_q + 1'b1;
  assign active_inc = (active_zone_q == LastZone) ? '0 : active_zone_q + 1'b1;

  // comparator operands and decisions
  always_comb begin
    cmp_then  = opened_at_q;
    cmp_limit = cfg.run_ms;
    if (state_q == izs_pkg::S_SCAN_EV) begin
      cmp_then  = lc_rdata;
      cmp_limit = cfg.retry_ms;
    end
    hum_stop = usable_q[active_zone_q] && (hum_rdata > cfg.stop_above);
    do_close = valve_on_q && (hum_stop || !allowed_q || cmp_ge);
    if (hum_stop) begin
      close_reason = izs_pkg::RSN_HUMIDITY;
    end else if (!allowed_q) begin
      close_reason = izs_pkg::RSN_WINDOW;
    end else begin
      close_reason = izs_pkg::RSN_RUNTIME;
    end
    scan_hit = usable_q[scan_z_q] && (hum_rdata < cfg.start_below) &&
               (!has_closed_q[scan_z_q] || cmp_ge);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      izs_pkg::S_IDLE: begin
        if (in_acc && (opcode_i == izs_pkg::OP_TICK)) begin
          state_d = izs_pkg::S_CLOSE;
        end
      end
      izs_pkg::S_CLOSE: begin
        if ((!valve_on_q || do_close) && allowed_q) begin
          state_d = izs_pkg::S_SCAN_RD;
        end else begin
          state_d = izs_pkg::S_FIN;
        end
      end
      izs_pkg::S_SCAN_RD: state_d = izs_pkg::S_SCAN_EV;
      izs_pkg::S_SCAN_EV: begin
        if (scan_hit || (scan_cnt_q == LastZone)) begin
          state_d = izs_pkg::S_FIN;
        end
      end
      izs_pkg::S_FIN: state_d = izs_pkg::S_IDLE;
      default: state_d = izs_pkg::S_IDLE;
    endcase
  end

  // datapath and result updates
  always_comb begin
    valve_on_d    = valve_on_q;
    active_zone_d = active_zone_q;
    opened_at_d   = opened_at_q;
    next_zone_d   = next_zone_q;
    has_closed_d  = has_closed_q;
    usable_d      = usable_q;
    now_d         = now_q;
    allowed_d     = allowed_q;
    scan_z_d      = scan_z_q;
    scan_cnt_d    = scan_cnt_q;
    res_closed_d  = res_closed_q;
    res_czone_d   = res_czone_q;
    res_reason_d  = res_reason_q;
    res_opened_d  = res_opened_q;
    res_ozone_d   = res_ozone_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_closed_d  = out_closed_q;
    out_czone_d   = out_czone_q;
    out_reason_d  = out_reason_q;
    out_opened_d  = out_opened_q;
    out_ozone_d   = out_ozone_q;
    out_active_d  = out_active_q;
    mem_raddr     = active_zone_q;
    hum_we        = 1'b0;
    lc_we         = 1'b0;
    unique case (state_q)
      izs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (opcode_i == izs_pkg::OP_SENSOR) begin
            if (sens_in_range) begin
              hum_we              = 1'b1;
              usable_d[sens_addr] = reading_usable_i;
            end
            out_valid_d  = 1'b1;
            out_closed_d = 1'b0;
            out_czone_d  = '0;
            out_reason_d = izs_pkg::RSN_HUMIDITY;
            out_opened_d = 1'b0;
            out_ozone_d  = '0;
            out_active_d = valve_on_q;
          end else begin
            now_d        = now_ms_i;
            allowed_d    = win_allowed;
            res_closed_d = 1'b0;
            res_czone_d  = '0;
            res_reason_d = izs_pkg::RSN_HUMIDITY;
            res_opened_d = 1'b0;
            res_ozone_d  = '0;
          end
        end
      end
      izs_pkg::S_CLOSE: begin
        scan_cnt_d = '0;
        scan_z_d   = next_zone_q;
        if (do_close) begin
          lc_we                       = 1'b1;
          has_closed_d[active_zone_q] = 1'b1;
          next_zone_d                 = active_inc;
          scan_z_d                    = active_inc;
          valve_on_d                  = 1'b0;
          res_closed_d                = 1'b1;
          res_czone_d                 = active_zone_q;
          res_reason_d                = close_reason;
        end
      end
      izs_pkg::S_SCAN_RD: begin
        mem_raddr = scan_z_q;
      end
      izs_pkg::S_SCAN_EV: begin
        mem_raddr = scan_z_inc;
        if (scan_hit) begin
          valve_on_d    = 1'b1;
          active_zone_d = scan_z_q;
          opened_at_d   = now_q;
          res_opened_d  = 1'b1;
          res_ozone_d   = scan_z_q;
        end else begin
          scan_z_d   = scan_z_inc;
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      izs_pkg::S_FIN: begin
        out_valid_d  = 1'b1;
        out_closed_d = res_closed_q;
        out_czone_d  = izs_pkg::ZoneIdxW'(res_czone_q);
        out_reason_d = res_reason_q;
        out_opened_d = res_opened_q;
        out_ozone_d  = izs_pkg::ZoneIdxW'(res_ozone_q);
        out_active_d = valve_on_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= izs_pkg::S_IDLE;
      valve_on_q    <= 1'b0;
      active_zone_q <= '0;
      opened_at_q   <= '0;
      next_zone_q   <= '0;
      has_closed_q  <= '0;
      usable_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      valve_on_q    <= valve_on_d;
      active_zone_q <= active_zone_d;
      opened_at_q   <= opened_at_d;
      next_zone_q   <= next_zone_d;
      has_closed_q  <= has_closed_d;
      usable_q      <= usable_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    allowed_q    <= allowed_d;
    scan_z_q     <= scan_z_d;
    scan_cnt_q   <= scan_cnt_d;
    res_closed_q <= res_closed_d;
    res_czone_q  <= res_czone_d;
    res_reason_q <= res_reason_d;
    res_opened_q <= res_opened_d;
    res_ozone_q  <= res_ozone_d;
    out_closed_q <= out_closed_d;
    out_czone_q  <= out_czone_d;
    out_reason_q <= out_reason_d;
    out_opened_q <= out_opened_d;
    out_ozone_q  <= out_ozone_d;
    out_active_q <= out_active_d;
  end

  assign out_valid_o    = out_valid_q;
  assign valve_closed_o = out_closed_q;
  assign closed_zone_o  = out_czone_q;
  assign close_reason_o = out_reason_q;
  assign valve_opened_o = out_opened_q;
  assign opened_zone_o  = out_ozone_q;
  assign valve_active_o = out_active_q;

`ifndef ASSERT_OFF
  // an opened valve is still open in the same result
  a_open_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valve_opened_o) |-> valve_active_o)
    else $error("opened valve not reported active");

  // a tick request blocks the next request
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (opcode_i == izs_pkg::OP_TICK)) |=> !in_ready_o)
    else $error("ready during tick processing");

  // the search never passes the last zone offset
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == izs_pkg::S_SCAN_EV) |-> (scan_cnt_q <= LastZone))
    else $error("search ran past all zones");

  // a valve opens only through a search hit
  a_open_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valve_on_q) |-> (res_opened_q && $past(state_q == izs_pkg::S_SCAN_EV)))
    else $error("valve opened outside the search");
`endif

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the irrigation zone scheduler. A short table of
// hand-written requests (some with results typed in) is followed by random
// phases, each under its own register setting. A typed-in result is checked
// as typed, any other against a cycle-free scheduler predictor in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import izs_pkg::*;

  localparam int NZ = NumZonesDef;

  typedef struct packed {
    logic                closed;
    logic [ZoneIdxW-1:0] closed_zone;
    reason_e             reason;
    logic                opened;
    logic [ZoneIdxW-1:0] opened_zone;
    logic                active;
  } valve_report_t;

  // one line of the hand-written stimulus table
  typedef struct packed {
    logic                is_cfg;
    cfg_idx_e            cidx;
    logic [CfgDataW-1:0] cdata;
    opcode_e             op;
    logic [ZoneIdxW-1:0] zone;
    logic [HumW-1:0]     hum;
    logic                usable;
    logic [TimeW-1:0]    now;
    logic [MinuteW-1:0]  minute;
    logic                clk_ok;
    logic                typed;
    valve_report_t       want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                opcode_i = 1'b0;
  logic [ZoneIdxW-1:0] zone_index_i = '0;
  logic [HumW-1:0]     humidity_tenths_i = '0;
  logic                reading_usable_i = 1'b0;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic [MinuteW-1:0]  minute_of_day_i = '0;
  logic                clock_valid_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                valve_closed_o;
  logic [ZoneIdxW-1:0] closed_zone_o;
  logic [1:0]          close_reason_o;
  logic                valve_opened_o;
  logic [ZoneIdxW-1:0] opened_zone_o;
  logic                valve_active_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // shadow registers
  logic               start_mode_s;
  logic [MinuteW-1:0] win_start_s, win_end_s;
  logic [SecW-1:0]    run_limit_s, retry_s;
  logic [HumW-1:0]    start_below_s, stop_above_s;

  // shadow scheduler state
  logic                valve_on_s;
  logic [ZoneIdxW-1:0] active_zone_s, next_zone_s;
  logic [TimeW-1:0]    opened_at_s;
  logic [TimeW-1:0]    last_close_s [NZ];
  logic                closed_once_s [NZ];
  logic [HumW-1:0]     humidity_s [NZ];
  logic                usable_s [NZ];

  valve_report_t due_reports [$];
  dir_row_t      dir_rows [$];
  logic          row_has_want = 1'b0;
  valve_report_t row_want;
  logic          quiet = 1'b0;

  int n_fail = 0;
  int n_req = 0;
  int n_tick = 0;
  int n_open = 0;
  int n_settings = 0;
  int n_close [3] = '{0, 0, 0};

  irrigation_zone_scheduler_unit #(
    .NUM_ZONES(NZ)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .zone_index_i     (zone_index_i),
    .humidity_tenths_i(humidity_tenths_i),
    .reading_usable_i (reading_usable_i),
    .now_ms_i         (now_ms_i),
    .minute_of_day_i  (minute_of_day_i),
    .clock_valid_i    (clock_valid_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .valve_closed_o   (valve_closed_o),
    .closed_zone_o    (closed_zone_o),
    .close_reason_o   (close_reason_o),
    .valve_opened_o   (valve_opened_o),
    .opened_zone_o    (opened_zone_o),
    .valve_active_o   (valve_active_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic valve_report_t rep(logic c, int cz, reason_e rs, logic o, int oz,
                                       logic a);
    valve_report_t v;
    v.closed      = c;
    v.closed_zone = cz[ZoneIdxW-1:0];
    v.reason      = rs;
    v.opened      = o;
    v.opened_zone = oz[ZoneIdxW-1:0];
    v.active      = a;
    return v;
  endfunction

  function automatic void put_req(opcode_e op, int zone, int hum, logic usable,
                                  logic [TimeW-1:0] now, int minute, logic clk_ok,
                                  logic typed, valve_report_t want);
    dir_row_t d;
    d        = '0;
    d.op     = op;
    d.zone   = zone[ZoneIdxW-1:0];
    d.hum    = hum[HumW-1:0];
    d.usable = usable;
    d.now    = now;
    d.minute = minute[MinuteW-1:0];
    d.clk_ok = clk_ok;
    d.typed  = typed;
    d.want   = want;
    dir_rows.push_back(d);
  endfunction

  function automatic void put_cfg(cfg_idx_e idx, int data);
    dir_row_t d;
    d        = '0;
    d.is_cfg = 1'b1;
    d.cidx   = idx;
    d.cdata  = data[CfgDataW-1:0];
    dir_rows.push_back(d);
  endfunction

  function automatic logic window_open(logic [MinuteW-1:0] minute, logic clk_ok);
    if (!start_mode_s) return 1'b1;
    if (!clk_ok) return 1'b0;
    if (win_start_s <= win_end_s) return minute >= win_start_s && minute <= win_end_s;
    return minute >= win_start_s || minute <= win_end_s;
  endfunction

  // applies one request to the shadow state and returns the valve report
  function automatic valve_report_t sched_apply(opcode_e op, logic [ZoneIdxW-1:0] zone,
                                                logic [HumW-1:0] hum, logic usable,
                                                logic [TimeW-1:0] now,
                                                logic [MinuteW-1:0] minute, logic clk_ok);
    valve_report_t       v;
    logic                allowed, do_close, found;
    logic [ZoneIdxW-1:0] z;
    logic [TimeW-1:0]    diff;
    int                  k, idx;
    v = rep(1'b0, 0, RSN_HUMIDITY, 1'b0, 0, 1'b0);
    if (op == OP_SENSOR) begin
      if (int'(zone) < NZ) begin
        humidity_s[zone] = hum;
        usable_s[zone]   = usable;
      end
    end else begin
      allowed = window_open(minute, clk_ok);
      // close first, wet beats window beats run time
      if (valve_on_s) begin
        z        = active_zone_s;
        do_close = 1'b1;
        diff     = now - opened_at_s;
        if (usable_s[z] && humidity_s[z] > stop_above_s) v.reason = RSN_HUMIDITY;
        else if (!allowed) v.reason = RSN_WINDOW;
        else if (diff / MsPerSec >= {16'd0, run_limit_s}) v.reason = RSN_RUNTIME;
        else do_close = 1'b0;
        if (do_close) begin
          v.closed          = 1'b1;
          v.closed_zone     = z;
          last_close_s[z]   = now;
          closed_once_s[z]  = 1'b1;
          next_zone_s       = (int'(z) == NZ - 1) ? '0 : z + 1'b1;
          valve_on_s        = 1'b0;
        end else begin
          v.reason = RSN_HUMIDITY;
        end
      end
      // round-robin search for a dry, rested zone
      if (!valve_on_s && allowed) begin
        found = 1'b0;
        for (k = 0; k < NZ; k++) begin
          idx  = (int'(next_zone_s) + k) % NZ;
          z    = idx[ZoneIdxW-1:0];
          diff = now - last_close_s[z];
          if (!found && usable_s[z] && humidity_s[z] < start_below_s &&
              (!closed_once_s[z] || diff / MsPerSec >= {16'd0, retry_s})) begin
            found         = 1'b1;
            valve_on_s    = 1'b1;
            active_zone_s = z;
            opened_at_s   = now;
            v.opened      = 1'b1;
            v.opened_zone = z;
          end
        end
      end
    end
    v.active = valve_on_s;
    return v;
  endfunction

  task automatic push_req(input opcode_e op, input logic [ZoneIdxW-1:0] zone,
                          input logic [HumW-1:0] hum, input logic usable,
                          input logic [TimeW-1:0] now, input logic [MinuteW-1:0] minute,
                          input logic clk_ok, input logic typed, input valve_report_t want);
    int gap;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid_i <= 1'b0;
    end
    @(negedge clk);
    row_has_want      = typed;
    row_want          = want;
    in_valid_i        <= 1'b1;
    opcode_i          <= op;
    zone_index_i      <= zone;
    humidity_tenths_i <= hum;
    reading_usable_i  <= usable;
    now_ms_i          <= now;
    minute_of_day_i   <= minute;
    clock_valid_i     <= clk_ok;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    repeat ($urandom_range(0, 2)) @(negedge clk);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    int n_on, n_off;
    forever begin
      n_on = quiet ? $urandom_range(20, 60) : $urandom_range(1, 8);
      repeat (n_on) begin
        @(negedge clk);
        out_ready_i <= 1'b1;
      end
      n_off = quiet ? 0 : pick_gap();
      repeat (n_off) begin
        @(negedge clk);
        out_ready_i <= 1'b0;
      end
    end
  end

  // results are retired before the request of the same edge is predicted
  always @(posedge clk) begin
    valve_report_t got, want, calc;
    logic          bad;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.closed      = valve_closed_o;
        got.closed_zone = closed_zone_o;
        got.reason      = reason_e'(close_reason_o);
        got.opened      = valve_opened_o;
        got.opened_zone = opened_zone_o;
        got.active      = valve_active_o;
        if (due_reports.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("%0t: result with no request pending: %p", $realtime, got);
        end else begin
          want = due_reports.pop_front();
          bad  = (got.closed !== want.closed) || (got.closed_zone !== want.closed_zone) ||
                 (got.reason !== want.reason) || (got.opened !== want.opened) ||
                 (got.opened_zone !== want.opened_zone) || (got.active !== want.active);
          if (bad) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: mismatch closed/zone/reason/opened/zone/active", $realtime);
              $display("  expected %0d/%0d/%0d/%0d/%0d/%0d", want.closed, want.closed_zone,
                       want.reason, want.opened, want.opened_zone, want.active);
              $display("  actual   %0d/%0d/%0d/%0d/%0d/%0d", got.closed, got.closed_zone,
                       got.reason, got.opened, got.opened_zone, got.active);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        calc = sched_apply(opcode_e'(opcode_i), zone_index_i, humidity_tenths_i,
                           reading_usable_i, now_ms_i, minute_of_day_i, clock_valid_i);
        due_reports.push_back(row_has_want ? row_want : calc);
        n_req++;
        if (opcode_i == OP_TICK) n_tick++;
        if (calc.opened) n_open++;
        if (calc.closed) n_close[calc.reason]++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_START_MODE:  start_mode_s  = cfg_data_i[0];
          CFG_WIN_START:   win_start_s   = cfg_data_i[MinuteW-1:0];
          CFG_WIN_END:     win_end_s     = cfg_data_i[MinuteW-1:0];
          CFG_RUN_LIMIT:   run_limit_s   = cfg_data_i[SecW-1:0];
          CFG_RETRY_DELAY: retry_s       = cfg_data_i[SecW-1:0];
          CFG_START_BELOW: start_below_s = cfg_data_i[HumW-1:0];
          CFG_STOP_ABOVE:  stop_above_s  = cfg_data_i[HumW-1:0];
          default: ;
        endcase
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    valve_report_t      none;
    dir_row_t           d;
    logic [CfgDataW-1:0] cv [7];
    int unsigned        t_now, step, win_ms;
    int                 p, i, k, r, h, m, span;
    none = rep(1'b0, 0, RSN_HUMIDITY, 1'b0, 0, 1'b0);
    row_want = none;

    // shadow state after reset
    start_mode_s  = RstStartMode;
    win_start_s   = RstWinStart;
    win_end_s     = RstWinEnd;
    run_limit_s   = RstRunLimit;
    retry_s       = RstRetry;
    start_below_s = RstStartBel;
    stop_above_s  = RstStopAbv;
    valve_on_s    = 1'b0;
    active_zone_s = '0;
    next_zone_s   = '0;
    opened_at_s   = '0;
    for (k = 0; k < NZ; k++) begin
      last_close_s[k]  = '0;
      closed_once_s[k] = 1'b0;
      humidity_s[k]    = '0;
      usable_s[k]      = 1'b0;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // hand-written table, reset register values first
    put_req(OP_TICK, 0, 0, 0, 0, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 0));
    put_req(OP_SENSOR, 0, 1000, 1, 0, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 0));
    put_req(OP_SENSOR, 7, 0, 1, 0, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 0));
    put_req(OP_SENSOR, 3, 200, 0, 0, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 0));
    put_req(OP_TICK, 0, 0, 0, 1000, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 1, 7, 1));
    put_req(OP_SENSOR, 7, 1023, 1, 0, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 1));
    put_req(OP_TICK, 0, 0, 0, 2000, 0, 0, 1, rep(1, 7, RSN_HUMIDITY, 0, 0, 0));
    put_req(OP_SENSOR, 1, 299, 1, 0, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 0));
    // exactly at the start threshold is not dry
    put_req(OP_SENSOR, 2, 300, 1, 0, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 0));
    put_req(OP_TICK, 0, 0, 0, 3000, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 1, 1, 1));
    // run time one ms short, then exact
    put_req(OP_TICK, 0, 0, 0, 602999, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 1));
    put_req(OP_TICK, 0, 0, 0, 603000, 0, 0, 1, rep(1, 1, RSN_RUNTIME, 0, 0, 0));
    // retry delay one ms short, then exact
    put_req(OP_TICK, 0, 0, 0, 4202999, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 0));
    put_req(OP_TICK, 0, 0, 0, 4203000, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 1, 1, 1));
    // unusable wet reading never forces a stop
    put_req(OP_SENSOR, 1, 601, 0, 0, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 1));
    put_req(OP_TICK, 0, 0, 0, 4204000, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 1));
    // window that wraps past midnight
    put_cfg(CFG_START_MODE, 1);
    put_cfg(CFG_WIN_START, 1430);
    put_cfg(CFG_WIN_END, 10);
    put_req(OP_TICK, 0, 0, 0, 4205000, 5, 1, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 1));
    put_req(OP_TICK, 0, 0, 0, 4206000, 720, 1, 1, rep(1, 1, RSN_WINDOW, 0, 0, 0));
    put_req(OP_SENSOR, 4, 0, 1, 0, 0, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 0));
    // unknown wall clock blocks watering
    put_req(OP_TICK, 0, 0, 0, 4207000, 1439, 0, 1, rep(0, 0, RSN_HUMIDITY, 0, 0, 0));
    put_req(OP_TICK, 0, 0, 0, 4208000, 1430, 1, 1, rep(0, 0, RSN_HUMIDITY, 1, 4, 1));
    put_req(OP_TICK, 0, 0, 0, 4209000, 11, 1, 1, rep(1, 4, RSN_WINDOW, 0, 0, 0));
    // zero retry and zero run time: close and reopen the same zone across wrap
    put_cfg(CFG_RETRY_DELAY, 0);
    put_req(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF, 10, 1, 1, rep(0, 0, RSN_HUMIDITY, 1, 4, 1));
    put_cfg(CFG_RUN_LIMIT, 0);
    put_req(OP_TICK, 7, 1023, 1, 32'h0000_0005, 2047, 1, 0, none);
    put_req(OP_SENSOR, 6, 512, 1, 32'hFFFF_FFFF, 2047, 1, 0, none);

    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      if (d.is_cfg) begin
        settle();
        cfg_write(d.cidx, d.cdata);
      end else begin
        push_req(d.op, d.zone, d.hum, d.usable, d.now, d.minute, d.clk_ok, d.typed,
                 d.want);
      end
    end

    // random phases, each under one register setting
    for (p = 0; p < 8; p++) begin
      case (p)
        0: cv = '{0, 360, 480, 5, 8, 300, 600};
        1: cv = '{1, 100, 140, 0, 0, 500, 500};
        2: cv = '{1, 1400, 30, 65535, 65535, 1000, 0};
        3: cv = '{0, 0, 0, 3, 0, 0, 1000};
        4: cv = '{1, 0, 1439, 2, 1, 1000, 1000};
        5: cv = '{1, 700, 700, 1, 2, 400, 300};
        default: begin
          cv[0] = $urandom_range(0, 1);
          cv[1] = $urandom_range(0, 1439);
          cv[2] = $urandom_range(0, 1439);
          cv[3] = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 20);
          cv[4] = $urandom_range(0, 30);
          cv[5] = $urandom_range(0, 1000);
          cv[6] = $urandom_range(0, 1000);
        end
      endcase
      settle();
      for (k = 0; k < 7; k++) cfg_write(cfg_idx_e'(k), cv[k]);
      n_settings++;
      t_now = $urandom();
      for (i = 0; i < 90; i++) begin
        if (i % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (r < 48) begin
          // sensor reading, humidity aimed at the thresholds
          r = $urandom_range(0, 99);
          if (r < 30) h = $urandom_range(0, start_below_s);
          else if (r < 55) h = $urandom_range(stop_above_s, 1000);
          else if (r < 80)
            h = ((r & 1) ? int'(start_below_s) : int'(stop_above_s)) + $urandom_range(0, 4) - 2;
          else if (r < 95) h = $urandom_range(0, 1000);
          else h = $urandom_range(1001, 1023);
          if (h < 0) h = 0;
          push_req(OP_SENSOR, $urandom_range(0, NZ - 1), h[HumW-1:0],
                   ($urandom_range(0, 99) < 85), $urandom(), $urandom_range(0, 2047),
                   $urandom_range(0, 1), 1'b0, none);
        end else begin
          // tick: time steps around the run and retry limits, some huge jumps
          r = $urandom_range(0, 99);
          win_ms = int'(run_limit_s) * 1000;
          if (r < 35) step = $urandom_range(0, 1500);
          else if (r < 62) step = $urandom_range(0, win_ms + 1500);
          else if (r < 80) begin
            step = int'(retry_s) * 1000 + $urandom_range(0, 2000);
            if (step >= 1000) step = step - 1000;
          end else if (r < 95) step = $urandom_range(0, 100000);
          else step = $urandom();
          t_now = t_now + step;
          // minute aimed at the window and its edges
          span = (int'(win_end_s) - int'(win_start_s) + 1440) % 1440;
          r = $urandom_range(0, 99);
          if (r < 40) m = $urandom_range(0, 1439);
          else if (r < 75) m = (int'(win_start_s) + $urandom_range(0, span + 2)) % 1440;
          else if (r < 90) begin
            case ($urandom_range(0, 3))
              0: m = win_start_s;
              1: m = win_end_s;
              2: m = (int'(win_start_s) + 1439) % 1440;
              default: m = (int'(win_end_s) + 1) % 1440;
            endcase
          end else m = $urandom_range(1440, 2047);
          push_req(OP_TICK, $urandom_range(0, NZ - 1), $urandom_range(0, 1023),
                   $urandom_range(0, 1), t_now, m[MinuteW-1:0],
                   ($urandom_range(0, 99) < 92), 1'b0, none);
        end
      end
      quiet = 1'b0;
    end

    settle();
    repeat (3 * NZ + 20) @(posedge clk);

    $display("Covered %0d requests (%0d ticks) under %0d random register settings",
             n_req, n_tick, n_settings);
    $display("Valve opens %0d; closes on humidity %0d, window %0d, run time %0d",
             n_open, n_close[0], n_close[1], n_close[2]);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failing results", n_fail);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
